>>> sv/lbfvt_pkg.sv
// Shared constants, payload types and helper functions of the fault vote tracker.
package lbfvt_pkg;

  localparam int unsigned MAX_BALANCERS = 16;
  localparam int unsigned MAX_SERVERS   = 16;
  localparam int unsigned LB_W          = $clog2(MAX_BALANCERS);
  localparam int unsigned ROW_W         = MAX_BALANCERS + MAX_SERVERS;
  localparam int unsigned VOTER_W       = 5;
  localparam int unsigned CNT_W         = 5;
  localparam int unsigned HASH_W        = 31;
  localparam int unsigned FB_W          = 3;
  localparam int unsigned CFG_W         = 5;

  // Request codes carried in req_type.
  localparam logic [1:0] REQ_VOTE  = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_STEER = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_OWN_ID       = 2'd0;
  localparam logic [1:0] CFG_FAULT_BOUND  = 2'd1;
  localparam logic [1:0] CFG_LB_COUNT     = 2'd2;
  localparam logic [1:0] CFG_SERVER_COUNT = 2'd3;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [LB_W-1:0]    target_lb;
    logic [VOTER_W-1:0] voter;
    logic [HASH_W-1:0]  lb_hash;
  } req_t;

  typedef struct packed {
    logic            send_vote;
    logic            marked_faulty;
    logic [LB_W-1:0] chosen_lb;
    logic            forward_local;
    logic            none_available;
  } res_t;

  // Ring size in use: zero acts as one, anything above the maximum is clipped.
  function automatic logic [CNT_W-1:0] ring_size(logic [CFG_W-1:0] lb_count);
    logic [CNT_W-1:0] n;
    n = lb_count;
    if (lb_count == '0) n = CNT_W'(1);
    if (lb_count > CFG_W'(MAX_BALANCERS)) n = CNT_W'(MAX_BALANCERS);
    return n;
  endfunction

  function automatic logic [CNT_W-1:0] server_size(logic [CFG_W-1:0] server_count);
    logic [CNT_W-1:0] s;
    s = server_count;
    if (server_count > CFG_W'(MAX_SERVERS)) s = CNT_W'(MAX_SERVERS);
    return s;
  endfunction

endpackage

>>> sv/lbfvt_req_if.sv
// Request channel: valid, ready and one request word.
interface lbfvt_req_if;
  logic              valid;
  logic              ready;
  lbfvt_pkg::req_t   payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> sv/lbfvt_res_if.sv
// Result channel: valid, ready and one result word.
interface lbfvt_res_if;
  logic              valid;
  logic              ready;
  lbfvt_pkg::res_t   payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> sv/lbfvt_mod.sv
// Restoring remainder unit: one dividend bit per cycle against a small divisor.
module lbfvt_mod (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [lbfvt_pkg::HASH_W-1:0]     dividend_i,
  input  logic [lbfvt_pkg::CNT_W-1:0]      divisor_i,
  output logic                             done_o,
  output logic [lbfvt_pkg::CNT_W-1:0]      rem_o
);

  localparam int unsigned ITER_W = $clog2(lbfvt_pkg::HASH_W);

  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [ITER_W-1:0]              iter_q, iter_d;
  logic [lbfvt_pkg::HASH_W-1:0]   dvd_q, dvd_d;
  logic [lbfvt_pkg::CNT_W-1:0]    dvs_q, dvs_d;
  logic [lbfvt_pkg::CNT_W-1:0]    rem_q, rem_d;
  logic [lbfvt_pkg::CNT_W:0]      trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    iter_d = iter_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    trial  = {rem_q, dvd_q[lbfvt_pkg::HASH_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      iter_d = '0;
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      // The partial remainder stays below the divisor, so it fits after the subtract.
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = lbfvt_pkg::CNT_W'(trial - {1'b0, dvs_q});
      end else begin
        rem_d = trial[lbfvt_pkg::CNT_W-1:0];
      end
      dvd_d  = {dvd_q[lbfvt_pkg::HASH_W-2:0], 1'b0};
      iter_d = iter_q + ITER_W'(1);
      if (iter_q == ITER_W'(lbfvt_pkg::HASH_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      iter_q <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

>>> sv/lb_fault_vote_tracker_core.sv
// Fault vote tracker for a ring of load balancers, with hash steering of requests.
//
// One request word is taken at a time. A clear, an unused code or a vote that is ignored
// goes straight to the output step. A counted vote or a steer first runs the remainder
// unit and then walks the ring at one balancer per cycle: a vote over the whole active ring,
// a steer until the first balancer that is not faulty. A new request is taken while the
// previous result still waits in the output register. Votes and faulty marks live in
// flip-flops that reset clears at once.
module lb_fault_vote_tracker_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_idx_i,
  input  logic [lbfvt_pkg::CFG_W-1:0]    cfg_data_i,
  lbfvt_req_if.sink                      req_i,
  lbfvt_res_if.source                    res_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_COUNT,
    S_WALK,
    S_DECIDE,
    S_OUT
  } state_e;

  localparam int unsigned LB_W  = lbfvt_pkg::LB_W;
  localparam int unsigned CNT_W = lbfvt_pkg::CNT_W;
  localparam int unsigned ROW_W = lbfvt_pkg::ROW_W;
  localparam int unsigned NB    = lbfvt_pkg::MAX_BALANCERS;

  state_e                          state_q, state_d;
  logic [LB_W-1:0]                 own_id_q, own_id_d;
  logic [lbfvt_pkg::FB_W-1:0]      fault_bound_q, fault_bound_d;
  logic [lbfvt_pkg::CFG_W-1:0]     lb_count_q, lb_count_d;
  logic [lbfvt_pkg::CFG_W-1:0]     server_count_q, server_count_d;
  logic [ROW_W-1:0]                vote_q [NB];
  logic [ROW_W-1:0]                vote_d [NB];
  logic [NB-1:0]                   faulty_q, faulty_d;
  logic [1:0]                      kind_q, kind_d;
  logic [LB_W-1:0]                 tgt_q, tgt_d;
  logic [CNT_W-1:0]                idx_q, idx_d;
  logic [CNT_W-1:0]                cnt_q, cnt_d;
  logic [CNT_W-1:0]                span_q, span_d;
  logic                            own_w_q, own_w_d;
  logic [LB_W-1:0]                 lb_q, lb_d;
  lbfvt_pkg::res_t                 res_q, res_d;
  lbfvt_pkg::res_t                 out_q, out_d;
  logic                            out_valid_q, out_valid_d;

  logic [CNT_W-1:0]                n_eff;
  logic [CNT_W:0]                  voters;
  logic [ROW_W-1:0]                need_mask;
  logic [ROW_W-1:0]                row;
  logic                            watched;
  logic                            accept;
  logic                            div_start;
  logic [lbfvt_pkg::HASH_W-1:0]    div_dividend;
  logic                            div_done;
  logic [CNT_W-1:0]                div_rem;

  // Ring distance from target t forward to balancer w, with zero taken as n.
  function automatic logic [CNT_W-1:0] ring_dist(logic [LB_W-1:0] w, logic [LB_W-1:0] t,
                                                 logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] d;
    if (w >= t) begin
      d = {1'b0, w} - {1'b0, t};
    end else begin
      d = {1'b0, w} + n - {1'b0, t};
    end
    if (d == '0) d = n;
    return d;
  endfunction

  lbfvt_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (n_eff),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  assign n_eff  = lbfvt_pkg::ring_size(lb_count_q);
  assign voters = {1'b0, n_eff} + {1'b0, lbfvt_pkg::server_size(server_count_q)};
  assign accept = req_i.valid && req_i.ready;
  assign row    = vote_q[tgt_q];

  assign req_i.ready   = (state_q == S_IDLE);
  assign res_o.valid   = out_valid_q;
  assign res_o.payload = out_q;

  assign watched = ring_dist(idx_q[LB_W-1:0], tgt_q, n_eff) <= span_q;

  // Every voter but the target itself has to be present before a mark.
  always_comb begin
    for (int i = 0; i < ROW_W; i++) begin
      need_mask[i] = ((CNT_W + 1)'(i) < voters) && (CNT_W'(i) != {1'b0, tgt_q});
    end
  end

  always_comb begin
    state_d        = state_q;
    own_id_d       = own_id_q;
    fault_bound_d  = fault_bound_q;
    lb_count_d     = lb_count_q;
    server_count_d = server_count_q;
    vote_d         = vote_q;
    faulty_d       = faulty_q;
    kind_d         = kind_q;
    tgt_d          = tgt_q;
    idx_d          = idx_q;
    cnt_d          = cnt_q;
    span_d         = span_q;
    own_w_d        = own_w_q;
    lb_d           = lb_q;
    res_d          = res_q;
    out_d          = out_q;
    out_valid_d    = out_valid_q && !res_o.ready;
    div_start      = 1'b0;
    div_dividend   = {{(lbfvt_pkg::HASH_W - lbfvt_pkg::FB_W - 1){1'b0}}, fault_bound_q, 1'b0};

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lbfvt_pkg::CFG_OWN_ID:       own_id_d       = cfg_data_i[LB_W-1:0];
        lbfvt_pkg::CFG_FAULT_BOUND:  fault_bound_d  = cfg_data_i[lbfvt_pkg::FB_W-1:0];
        lbfvt_pkg::CFG_LB_COUNT:     lb_count_d     = cfg_data_i;
        lbfvt_pkg::CFG_SERVER_COUNT: server_count_d = cfg_data_i;
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          kind_d  = req_i.payload.req_type;
          tgt_d   = req_i.payload.target_lb;
          res_d   = '0;
          state_d = S_OUT;
          case (req_i.payload.req_type)
            lbfvt_pkg::REQ_VOTE: begin
              if (({1'b0, req_i.payload.target_lb} < n_eff) &&
                  !faulty_q[req_i.payload.target_lb]) begin
                if ({1'b0, req_i.payload.voter} < voters) begin
                  vote_d[req_i.payload.target_lb][req_i.payload.voter] = 1'b1;
                end
                // The remainder unit reduces 2f modulo the ring size for the watcher span.
                div_start = 1'b1;
                state_d   = S_DIV;
              end
            end
            lbfvt_pkg::REQ_CLEAR: begin
              vote_d[req_i.payload.target_lb]   = '0;
              faulty_d[req_i.payload.target_lb] = 1'b0;
            end
            lbfvt_pkg::REQ_STEER: begin
              div_dividend = req_i.payload.lb_hash;
              div_start    = 1'b1;
              state_d      = S_DIV;
            end
            default: ;
          endcase
        end
      end
      S_DIV: begin
        if (div_done) begin
          idx_d   = '0;
          cnt_d   = '0;
          own_w_d = 1'b0;
          span_d  = (div_rem == '0) ? n_eff : div_rem;
          lb_d    = div_rem[LB_W-1:0];
          state_d = (kind_q == lbfvt_pkg::REQ_STEER) ? S_WALK : S_COUNT;
        end
      end
      S_COUNT: begin
        if (watched && row[idx_q]) cnt_d = cnt_q + CNT_W'(1);
        if (idx_q == {1'b0, own_id_q}) own_w_d = watched;
        if (idx_q == n_eff - CNT_W'(1)) begin
          state_d = S_DECIDE;
        end else begin
          idx_d = idx_q + CNT_W'(1);
        end
      end
      S_DECIDE: begin
        if (own_w_q || (cnt_q >= ({2'b00, fault_bound_q} + CNT_W'(1)))) begin
          res_d.send_vote = 1'b1;
        end else if ((row & need_mask) == need_mask) begin
          faulty_d[tgt_q]     = 1'b1;
          res_d.marked_faulty = 1'b1;
        end
        state_d = S_OUT;
      end
      S_WALK: begin
        if (!faulty_q[lb_q]) begin
          res_d.chosen_lb     = lb_q;
          res_d.forward_local = (lb_q == own_id_q);
          state_d             = S_OUT;
        end else if (idx_q == n_eff - CNT_W'(1)) begin
          res_d.none_available = 1'b1;
          state_d              = S_OUT;
        end else begin
          lb_d  = ({1'b0, lb_q} == n_eff - CNT_W'(1)) ? '0 : lb_q + LB_W'(1);
          idx_d = idx_q + CNT_W'(1);
        end
      end
      S_OUT: begin
        // The word moves out once the output register is free or being emptied.
        if (!out_valid_q || res_o.ready) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      own_id_q       <= '0;
      fault_bound_q  <= lbfvt_pkg::FB_W'(1);
      lb_count_q     <= lbfvt_pkg::CFG_W'(4);
      server_count_q <= lbfvt_pkg::CFG_W'(4);
      faulty_q       <= '0;
      out_valid_q    <= 1'b0;
      for (int i = 0; i < NB; i++) begin
        vote_q[i] <= '0;
      end
    end else begin
      state_q        <= state_d;
      own_id_q       <= own_id_d;
      fault_bound_q  <= fault_bound_d;
      lb_count_q     <= lb_count_d;
      server_count_q <= server_count_d;
      faulty_q       <= faulty_d;
      out_valid_q    <= out_valid_d;
      vote_q         <= vote_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    tgt_q   <= tgt_d;
    idx_q   <= idx_d;
    cnt_q   <= cnt_d;
    span_q  <= span_d;
    own_w_q <= own_w_d;
    lb_q    <= lb_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

endmodule
